### design/jac_pkg.sv
// Shared types, constants and tables for the joystick axis calibration block.
`default_nettype none

package jac_pkg;

    localparam int AXIS_W             = 16;
    localparam int TIME_W             = 63;
    localparam int KEY_N              = 8;
    localparam int QUO_W              = 15;
    localparam int DIGIT_W            = 4;
    localparam int TIME_DIGITS        = 16;
    localparam int SUB_W              = DIGIT_W * TIME_DIGITS;
    localparam int CFG_IDX_W          = 3;
    localparam int ZONE_THRESHOLD_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG_MODE = 3'd6;

    localparam logic signed [AXIS_W-1:0] AXIS_POS_FULL = 16'sh7FFF;
    localparam logic signed [AXIS_W-1:0] AXIS_NEG_FULL = 16'sh8000;

    localparam logic signed [1:0] KEY_DH [KEY_N] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd1,
                                                      2'sd1, 2'sd0, -2'sd1, -2'sd1};
    localparam logic signed [1:0] KEY_DV [KEY_N] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                      2'sd1, 2'sd1, 2'sd1, 2'sd0};

    typedef struct packed {
        logic signed [AXIS_W-1:0] min_ref;
        logic signed [AXIS_W-1:0] center_ref;
        logic signed [AXIS_W-1:0] max_ref;
    } cal_t;

    typedef enum logic [1:0] {
        ZONE_NEG,
        ZONE_MID,
        ZONE_POS
    } zone_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TIME,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

### design/jac_axis.sv
// One axis lane: calibration end tests and a bit-serial restoring divider for the scaling.
`default_nettype none

module jac_axis (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [jac_pkg::AXIS_W-1:0]   raw,
    input  wire jac_pkg::cal_t                       cal,
    output logic                                     busy,
    output logic signed [jac_pkg::AXIS_W-1:0]        result
);
    import jac_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic signed [AXIS_W:0] raw_w;
    logic signed [AXIS_W:0] min_w;
    logic signed [AXIS_W:0] ctr_w;
    logic signed [AXIS_W:0] max_w;
    logic signed [AXIS_W:0] diff;
    logic                   pos;
    logic [AXIS_W:0]        mag;
    logic [AXIS_W:0]        den;
    logic [AXIS_W+1:0]      rem_dbl;
    logic                   quo_bit;

    logic                   busy_reg;
    logic                   busy_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [AXIS_W:0]        rem_reg;
    logic [AXIS_W:0]        rem_next;
    logic [AXIS_W:0]        den_reg;
    logic [QUO_W-1:0]       quo_reg;
    logic [QUO_W-1:0]       quo_next;
    logic                   neg_reg;
    logic                   sat_hi_reg;
    logic                   sat_lo_reg;

    always_comb
    begin
        raw_w = {raw[AXIS_W-1], raw};
        min_w = {cal.min_ref[AXIS_W-1], cal.min_ref};
        ctr_w = {cal.center_ref[AXIS_W-1], cal.center_ref};
        max_w = {cal.max_ref[AXIS_W-1], cal.max_ref};
        diff  = raw_w - ctr_w;
        pos   = raw_w > ctr_w;
        mag   = pos ? unsigned'(diff) : unsigned'(-diff);
        den   = pos ? unsigned'(max_w - ctr_w) : unsigned'(ctr_w - min_w);
    end

    always_comb
    begin
        rem_dbl   = {rem_reg, 1'b0};
        quo_bit   = rem_dbl >= {1'b0, den_reg};
        rem_next  = quo_bit ? (AXIS_W+1)'(rem_dbl - {1'b0, den_reg}) : rem_dbl[AXIS_W:0];
        quo_next  = {quo_reg[QUO_W-2:0], quo_bit};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg    <= mag;
            den_reg    <= den;
            quo_reg    <= '0;
            neg_reg    <= !pos;
            sat_hi_reg <= pos && (raw_w >= max_w);
            sat_lo_reg <= !pos && (raw_w <= min_w);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb
    begin
        priority if (sat_hi_reg)
        begin
            result = AXIS_POS_FULL;
        end
        else if (sat_lo_reg)
        begin
            result = AXIS_NEG_FULL;
        end
        else if (neg_reg)
        begin
            result = -signed'({1'b0, quo_reg});
        end
        else
        begin
            result = signed'({1'b0, quo_reg});
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

### design/joystick_axis_calibrate_repeat_unit.sv
// Top level of the joystick axis calibration and direction hold timing block.
// Each accepted word is captured, then scaled in the two per-axis restoring dividers that
// run side by side and produce one quotient bit per cycle, then used for the zone update,
// then passed through the 4-bit serial subtractor that forms the hold time, and at last
// loaded into the output register, after which the block is ready for the next word. A
// finished result waits in the output register while the next word is already being worked
// on, and the block only stalls at the end of that word if the result has still not been
// taken. Configuration writes are always taken and must only be issued while idle.
`default_nettype none

module joystick_axis_calibrate_repeat_unit #(
    parameter int ZONE_THRESHOLD = jac_pkg::ZONE_THRESHOLD_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [jac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [jac_pkg::AXIS_W-1:0]            cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [jac_pkg::AXIS_W-1:0]     raw_x,
    input  wire logic signed [jac_pkg::AXIS_W-1:0]     raw_y,
    input  wire logic [jac_pkg::TIME_W-1:0]            sample_time,
    input  wire logic                                  stick_present,
    input  wire logic [jac_pkg::KEY_N-1:0]             dir_keys,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [jac_pkg::AXIS_W-1:0]          axis_x,
    output logic signed [jac_pkg::AXIS_W-1:0]          axis_y,
    output logic [jac_pkg::TIME_W-1:0]                 held_time
);
    import jac_pkg::*;

    localparam logic signed [AXIS_W:0] THR = (AXIS_W+1)'(ZONE_THRESHOLD);
    localparam int TCNT_W = $clog2(TIME_DIGITS);
    localparam logic [TCNT_W-1:0] TCNT_LAST = TCNT_W'(TIME_DIGITS - 1);

    cal_t                     cal_x_reg;
    cal_t                     cal_y_reg;
    logic                     analog_mode_reg;

    state_t                   state_reg;
    state_t                   state_next;
    logic                     capture;
    logic                     zone_upd;
    logic                     time_step;
    logic                     load_out;

    logic                     busy_x;
    logic                     busy_y;
    logic signed [AXIS_W-1:0] res_x;
    logic signed [AXIS_W-1:0] res_y;

    logic [TIME_W-1:0]        now_reg;
    logic                     stick_reg;
    logic [KEY_N-1:0]         keys_reg;

    zone_t                    last_zone_x_reg;
    zone_t                    last_zone_y_reg;
    logic [TIME_W-1:0]        zone_change_time_reg;

    logic signed [3:0]        sum_h;
    logic signed [3:0]        sum_v;
    logic signed [AXIS_W-1:0] key_x;
    logic signed [AXIS_W-1:0] key_y;
    logic signed [AXIS_W-1:0] dx;
    logic signed [AXIS_W-1:0] dy;
    zone_t                    zone_x;
    zone_t                    zone_y;
    logic                     timed;
    logic                     changed;
    logic [TIME_W-1:0]        zct_new;

    logic signed [AXIS_W-1:0] dx_reg;
    logic signed [AXIS_W-1:0] dy_reg;
    logic                     timed_reg;
    logic [SUB_W-1:0]         sub_a_reg;
    logic [SUB_W-1:0]         sub_b_reg;
    logic [SUB_W-1:0]         diff_reg;
    logic                     borrow_reg;
    logic [DIGIT_W:0]         digit_sum;
    logic [TCNT_W-1:0]        tcnt_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [AXIS_W-1:0] axis_x_reg;
    logic signed [AXIS_W-1:0] axis_y_reg;
    logic [TIME_W-1:0]        held_time_reg;

    function automatic zone_t zone_of(input logic signed [AXIS_W-1:0] d);
        logic signed [AXIS_W:0] dw;
        dw = {d[AXIS_W-1], d};
        if (dw < -THR)
        begin
            return ZONE_NEG;
        end
        if (dw > THR)
        begin
            return ZONE_POS;
        end
        return ZONE_MID;
    endfunction

    function automatic logic signed [AXIS_W-1:0] full_scale(input logic signed [3:0] s);
        if (s == 4'sd0)
        begin
            return '0;
        end
        return s[3] ? AXIS_NEG_FULL : AXIS_POS_FULL;
    endfunction

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_x_reg       <= '{min_ref: AXIS_NEG_FULL, center_ref: '0, max_ref: AXIS_POS_FULL};
            cal_y_reg       <= '{min_ref: AXIS_NEG_FULL, center_ref: '0, max_ref: AXIS_POS_FULL};
            analog_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_MIN:       cal_x_reg.min_ref    <= signed'(cfg_data);
                REG_X_CENTER:    cal_x_reg.center_ref <= signed'(cfg_data);
                REG_X_MAX:       cal_x_reg.max_ref    <= signed'(cfg_data);
                REG_Y_MIN:       cal_y_reg.min_ref    <= signed'(cfg_data);
                REG_Y_CENTER:    cal_y_reg.center_ref <= signed'(cfg_data);
                REG_Y_MAX:       cal_y_reg.max_ref    <= signed'(cfg_data);
                REG_ANALOG_MODE: analog_mode_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    jac_axis u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (capture),
        .raw    (raw_x),
        .cal    (cal_x_reg),
        .busy   (busy_x),
        .result (res_x)
    );

    jac_axis u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (capture),
        .raw    (raw_y),
        .cal    (cal_y_reg),
        .busy   (busy_y),
        .result (res_y)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        capture    = 1'b0;
        zone_upd   = 1'b0;
        time_step  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    capture    = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!busy_x && !busy_y)
                begin
                    zone_upd   = 1'b1;
                    state_next = ST_TIME;
                end
            end
            ST_TIME:
            begin
                time_step = 1'b1;
                if (tcnt_reg == TCNT_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Keypad decode, zone tracking and hold time start.
    always_comb
    begin
        sum_h = '0;
        sum_v = '0;
        for (int i = 0; i < KEY_N; i++)
        begin
            if (keys_reg[i])
            begin
                sum_h = sum_h + {{2{KEY_DH[i][1]}}, KEY_DH[i]};
                sum_v = sum_v + {{2{KEY_DV[i][1]}}, KEY_DV[i]};
            end
        end
        key_x   = full_scale(sum_h);
        key_y   = full_scale(sum_v);
        dx      = stick_reg ? res_x : key_x;
        dy      = stick_reg ? res_y : key_y;
        zone_x  = zone_of(dx);
        zone_y  = zone_of(dy);
        timed   = !stick_reg || !analog_mode_reg;
        changed = timed && ((zone_x != last_zone_x_reg) || (zone_y != last_zone_y_reg));
        zct_new = changed ? now_reg : zone_change_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_zone_x_reg      <= ZONE_MID;
            last_zone_y_reg      <= ZONE_MID;
            zone_change_time_reg <= '0;
        end
        else if (zone_upd && changed)
        begin
            last_zone_x_reg      <= zone_x;
            last_zone_y_reg      <= zone_y;
            zone_change_time_reg <= now_reg;
        end
    end

    // Serial subtractor, one digit per cycle with the borrow carried over.
    assign digit_sum = {1'b0, sub_a_reg[DIGIT_W-1:0]} - {1'b0, sub_b_reg[DIGIT_W-1:0]}
                       - {{DIGIT_W{1'b0}}, borrow_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcnt_reg <= '0;
        end
        else if (zone_upd)
        begin
            tcnt_reg <= '0;
        end
        else if (time_step)
        begin
            tcnt_reg <= tcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            now_reg   <= sample_time;
            stick_reg <= stick_present;
            keys_reg  <= dir_keys;
        end
        if (zone_upd)
        begin
            dx_reg     <= dx;
            dy_reg     <= dy;
            timed_reg  <= timed;
            sub_a_reg  <= SUB_W'(now_reg);
            sub_b_reg  <= SUB_W'(zct_new);
            borrow_reg <= 1'b0;
        end
        else if (time_step)
        begin
            sub_a_reg  <= sub_a_reg >> DIGIT_W;
            sub_b_reg  <= sub_b_reg >> DIGIT_W;
            borrow_reg <= digit_sum[DIGIT_W];
            diff_reg   <= {digit_sum[DIGIT_W-1:0], diff_reg[SUB_W-1:DIGIT_W]};
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            axis_x_reg    <= dx_reg;
            axis_y_reg    <= dy_reg;
            held_time_reg <= timed_reg ? diff_reg[TIME_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign axis_x    = axis_x_reg;
    assign axis_y    = axis_y_reg;
    assign held_time = held_time_reg;

endmodule

`default_nettype wire

### verif/tb_joystick_axis_calibrate_repeat_unit.sv
// Self-checking testbench for the joystick axis calibration and zone hold timing unit.
`timescale 1ns / 1ps

module tb_joystick_axis_calibrate_repeat_unit;
    import jac_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_CYCLES = 400;
    localparam int FULL_POS     = 32767;
    localparam int FULL_NEG     = -32768;

    typedef struct {
        int lo;
        int mid;
        int hi;
    } axis_cal_t;

    typedef struct {
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic [TIME_W-1:0]        t;
        logic                     stick;
        logic [KEY_N-1:0]         keys;
    } sample_t;

    typedef struct {
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic [TIME_W-1:0]        held;
    } stick_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [AXIS_W-1:0]             cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [AXIS_W-1:0]      raw_x = '0;
    logic signed [AXIS_W-1:0]      raw_y = '0;
    logic [TIME_W-1:0]             sample_time = '0;
    logic                          stick_present = 1'b0;
    logic [KEY_N-1:0]              dir_keys = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [AXIS_W-1:0]      axis_x;
    logic signed [AXIS_W-1:0]      axis_y;
    logic [TIME_W-1:0]             held_time;

    axis_cal_t   cal_x = '{-32768, 0, 32767};
    axis_cal_t   cal_y = '{-32768, 0, 32767};
    bit          analog_on = 1'b0;
    zone_t       zone_x_now = ZONE_MID;
    zone_t       zone_y_now = ZONE_MID;
    logic [TIME_W-1:0] zone_since = '0;
    int          key_step_x [KEY_N] = '{-1, 0, 1, 1, 1, 0, -1, -1};
    int          key_step_y [KEY_N] = '{-1, -1, -1, 0, 1, 1, 1, 0};

    sample_t     sample_queue [$];
    stick_word_t expected_words [$];
    int          words_queued = 0;
    int          words_taken = 0;
    int          errors = 0;
    int          send_idle_pct = 7;
    int          recv_idle_pct = 61;
    int          stall_requests = 0;
    int          stalls_served = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    logic [TIME_W-1:0]        now_us = 63'd10000;
    logic signed [AXIS_W-1:0] hold_x = '0;
    logic signed [AXIS_W-1:0] hold_y = '0;
    logic                     hold_stick = 1'b1;
    logic [KEY_N-1:0]         hold_keys = '0;

    joystick_axis_calibrate_repeat_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .raw_x         (raw_x),
        .raw_y         (raw_y),
        .sample_time   (sample_time),
        .stick_present (stick_present),
        .dir_keys      (dir_keys),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .axis_x        (axis_x),
        .axis_y        (axis_y),
        .held_time     (held_time)
    );

    always #6 clk = ~clk;

    function automatic int calibrate_axis(input int v, input axis_cal_t c);
        longint q;
        if (v > c.mid)
        begin
            if (v >= c.hi)
                return FULL_POS;
            q = (longint'(v - c.mid) * 32768) / longint'(c.hi - c.mid);
        end
        else
        begin
            if (v <= c.lo)
                return FULL_NEG;
            q = (longint'(v - c.mid) * 32768) / longint'(c.mid - c.lo);
        end
        return int'(q);
    endfunction

    function automatic zone_t zone_of_axis(input int d);
        if (d < -ZONE_THRESHOLD_DEF)
            return ZONE_NEG;
        if (d > ZONE_THRESHOLD_DEF)
            return ZONE_POS;
        return ZONE_MID;
    endfunction

    function automatic stick_word_t predict_word(input logic signed [AXIS_W-1:0] rx,
                                                 input logic signed [AXIS_W-1:0] ry,
                                                 input logic [TIME_W-1:0] t,
                                                 input logic stick,
                                                 input logic [KEY_N-1:0] keys);
        stick_word_t w;
        int          dx;
        int          dy;
        int          sh;
        int          sv;
        int          k;
        zone_t       zx;
        zone_t       zy;
        bit          timed;
        sh = 0;
        sv = 0;
        if (stick)
        begin
            dx = calibrate_axis(rx, cal_x);
            dy = calibrate_axis(ry, cal_y);
            timed = !analog_on;
        end
        else
        begin
            for (k = 0; k < KEY_N; k++)
            begin
                if (keys[k])
                begin
                    sh += key_step_x[k];
                    sv += key_step_y[k];
                end
            end
            dx = (sh == 0) ? 0 : ((sh < 0) ? FULL_NEG : FULL_POS);
            dy = (sv == 0) ? 0 : ((sv < 0) ? FULL_NEG : FULL_POS);
            timed = 1'b1;
        end
        w.ax = 16'(dx);
        w.ay = 16'(dy);
        w.held = '0;
        if (timed)
        begin
            zx = zone_of_axis(dx);
            zy = zone_of_axis(dy);
            if (zx != zone_x_now || zy != zone_y_now)
            begin
                zone_x_now = zx;
                zone_y_now = zy;
                zone_since = t;
            end
            w.held = t - zone_since;
        end
        return w;
    endfunction

    function automatic logic signed [AXIS_W-1:0] pick_raw(input axis_cal_t c);
        int knee;
        case ($urandom_range(5))
            0, 1: return 16'($urandom);
            2: return 16'(c.mid + int'($urandom_range(0, 4000)) - 2000);
            3:
            begin
                case ($urandom_range(6))
                    0: return 16'(c.lo);
                    1: return 16'(c.hi);
                    2: return 16'(c.mid);
                    3: return 16'(c.lo + 1);
                    4: return 16'(c.hi - 1);
                    5: return 16'(c.mid + 1);
                    default: return 16'(c.mid - 1);
                endcase
            end
            default:
            begin
                if ($urandom_range(1))
                    knee = c.mid + int'((longint'(c.hi - c.mid) * 1024) / 32768);
                else
                    knee = c.mid - int'((longint'(c.mid - c.lo) * 1024) / 32768);
                return 16'(knee + int'($urandom_range(0, 4)) - 2);
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_sample(input logic signed [AXIS_W-1:0] rx,
                                input logic signed [AXIS_W-1:0] ry,
                                input logic [TIME_W-1:0] t,
                                input logic stick,
                                input logic [KEY_N-1:0] keys);
        sample_t s;
        s.rx = rx;
        s.ry = ry;
        s.t = t;
        s.stick = stick;
        s.keys = keys;
        sample_queue.push_back(s);
        words_queued++;
    endtask

    // Mostly steady stick positions and key sets with rising timestamps, so that
    // zones persist and hold times grow, mixed with jumps and backward steps.
    task automatic queue_random(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 88)
                now_us = now_us + 63'($urandom_range(0, 40000));
            else if (pick < 94)
                now_us = now_us - 63'($urandom_range(1, 5000));
            else
                now_us = 63'({$urandom, $urandom});
            if ($urandom_range(9) < 2)
                hold_stick = ~hold_stick;
            if ($urandom_range(9) < 4)
                hold_x = pick_raw(cal_x);
            if ($urandom_range(9) < 4)
                hold_y = pick_raw(cal_y);
            if ($urandom_range(9) < 5)
            begin
                if ($urandom_range(9) < 7)
                    hold_keys = 8'(1 << $urandom_range(7));
                else
                    hold_keys = 8'($urandom);
            end
            queue_sample(hold_x, hold_y, now_us, hold_stick, hold_keys);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AXIS_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_X_MIN:       cal_x.lo = $signed(val);
            REG_X_CENTER:    cal_x.mid = $signed(val);
            REG_X_MAX:       cal_x.hi = $signed(val);
            REG_Y_MIN:       cal_y.lo = $signed(val);
            REG_Y_CENTER:    cal_y.mid = $signed(val);
            REG_Y_MAX:       cal_y.hi = $signed(val);
            REG_ANALOG_MODE: analog_on = val[0];
            default: ;
        endcase
    endtask

    task automatic set_cal(input int xl, input int xm, input int xh,
                           input int yl, input int ym, input int yh, input bit am);
        write_reg(REG_X_MIN, 16'(xl));
        write_reg(REG_X_CENTER, 16'(xm));
        write_reg(REG_X_MAX, 16'(xh));
        write_reg(REG_Y_MIN, 16'(yl));
        write_reg(REG_Y_CENTER, 16'(ym));
        write_reg(REG_Y_MAX, 16'(yh));
        write_reg(REG_ANALOG_MODE, {15'd0, am});
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : feeder
        sample_t s;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s = sample_queue.pop_front();
                in_valid <= 1'b1;
                raw_x <= s.rx;
                raw_y <= s.ry;
                sample_time <= s.t;
                stick_present <= s.stick;
                dir_keys <= s.keys;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drain_side
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stalls_served != stall_requests)
        begin
            stalls_served <= stall_requests;
            stall_left <= STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        stick_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_words.push_back(predict_word(raw_x, raw_y, sample_time,
                                                      stick_present, dir_keys));
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("result word arrived with nothing expected");
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (axis_x !== want.ax)
                        report_mismatch($sformatf("axis_x got %0d, expected %0d",
                                                  axis_x, want.ax));
                    if (axis_y !== want.ay)
                        report_mismatch($sformatf("axis_y got %0d, expected %0d",
                                                  axis_y, want.ay));
                    if (held_time !== want.held)
                        report_mismatch($sformatf("held_time got %0d, expected %0d",
                                                  held_time, want.held));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_joystick_axis_calibrate_repeat_unit: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int phase;
        int xl;
        int xm;
        int xh;
        int yl;
        int ym;
        int yh;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        queue_sample(16'sh7FFF, 16'sh8000, 63'd0, 1'b1, 8'h00);
        queue_sample(16'sh0000, 16'sh0000, 63'd100, 1'b1, 8'hFF);
        queue_sample(16'sh0001, -16'sh0001, 63'd200, 1'b1, 8'h00);
        queue_sample(16'sd1025, -16'sd1024, 63'd300, 1'b1, 8'h00);
        queue_sample(16'sd1025, -16'sd1024, 63'd350, 1'b1, 8'h00);
        queue_sample(16'sh5555, 16'shAAAA, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 8'h00);
        queue_sample(16'shAAAA, 16'sh5555, 63'd5, 1'b1, 8'h00);
        queue_sample(16'shAAAA, 16'sh5555, 63'd3, 1'b1, 8'h00);
        queue_sample(16'sh7FFF, 16'sh8000, 63'd1000, 1'b0, 8'h00);
        for (int k = 0; k < KEY_N; k++)
            queue_sample(16'sh8000, 16'sh7FFF, 63'd1100 + 63'(100 * k), 1'b0, 8'(1 << k));
        queue_sample(16'sh1234, 16'sh4321, 63'd2500, 1'b0, 8'h80);
        queue_sample(16'sh0000, 16'sh0000, 63'd3000, 1'b0, 8'hFF);
        queue_sample(16'sh0000, 16'sh0000, 63'd3100, 1'b0, 8'h22);
        queue_sample(16'sh0000, 16'sh0000, 63'd3200, 1'b0, 8'h88);
        queue_sample(16'sh0000, 16'sh0000, 63'd3300, 1'b0, 8'h09);
        queue_random(97);
        wait_drained();

        for (phase = 1; phase < 8; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 7;
            end
            if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1: set_cal(-30000, 500, 31000, -20000, -1000, 25000, 1'b0);
                2: set_cal(-32768, 0, 32767, -32768, 0, 32767, 1'b1);
                3: set_cal(-32768, -32768, 32767, -32768, 32767, 32767, 1'b0);
                4: set_cal(100, 0, -100, 32767, 0, -32768, 1'b1);
                5: set_cal(0, 0, 0, 32767, 32767, 32767, 1'b0);
                6:
                begin
                    xl = -32768 + int'($urandom_range(0, 30000));
                    xm = xl + int'($urandom_range(1, 20000));
                    xh = xm + int'($urandom_range(1, 32767 - xm));
                    yl = -32768 + int'($urandom_range(0, 30000));
                    ym = yl + int'($urandom_range(1, 20000));
                    yh = ym + int'($urandom_range(1, 32767 - ym));
                    set_cal(xl, xm, xh, yl, ym, yh, 1'($urandom));
                end
                default: set_cal(-5, 0, 5, -1, 0, 1, 1'b0);
            endcase
            queue_random(97);
            if (phase == 1)
                stall_requests <= stall_requests + 1;
            wait_drained();
        end

        if (errors == 0)
            $display("tb_joystick_axis_calibrate_repeat_unit: done, clean");
        else
            $display("tb_joystick_axis_calibrate_repeat_unit: done, errors");
        $finish;
    end

endmodule
